// File: hw/rtl/gregorian_date_step_compare_assert.svh
// ----------------------------------------------------------------------------
// Assertion macros for the Gregorian date stepper
// Shared concurrent assertion forms, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef GREGORIAN_DATE_STEP_COMPARE_ASSERT_SVH
`define GREGORIAN_DATE_STEP_COMPARE_ASSERT_SVH

`ifndef ASSERT_OFF

// The consequent must hold in the same cycle as the antecedent.
`define GDSC_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define GDSC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`else

`define GDSC_ASSERT_SAME(lbl, ante, cons, msg)
`define GDSC_ASSERT_NEXT(lbl, ante, cons, msg)

`endif

`endif

// File: hw/rtl/gdsc_pkg.sv
// ----------------------------------------------------------------------------
// gdsc_pkg
// Types, constants and calendar helpers of the Gregorian date stepper.
// ----------------------------------------------------------------------------
package gdsc_pkg;

  localparam int unsigned YEAR_BITS = 16;

  typedef logic [YEAR_BITS-1:0] year_t;
  typedef logic [4:0]           day_t;
  typedef logic [3:0]           month_t;
  typedef logic [1:0]           order_t;

  // Result codes of the date ordering.
  localparam order_t ORDER_EQUAL   = 2'd0;
  localparam order_t ORDER_EARLIER = 2'd1;
  localparam order_t ORDER_LATER   = 2'd2;

  localparam month_t MONTH_JAN = 4'd1;
  localparam month_t MONTH_FEB = 4'd2;
  localparam month_t MONTH_DEC = 4'd12;
  localparam day_t   DAY_FIRST = 5'd1;
  localparam day_t   DAY_LAST_DEC = 5'd31;

  // A century year is a multiple of 4 and of this odd factor.
  localparam logic [63:0] CenturyFactor = 64'd25;

  // Inverse of an odd number modulo 2^64 by Newton iteration (elaboration only).
  function automatic logic [63:0] odd_inverse(input logic [63:0] a);
    logic [63:0] x;
    x = a;
    for (int i = 0; i < 6; i++) begin
      x = x * (64'd2 - a * x);
    end
    return x;
  endfunction

  // Exact divisibility test: y is a multiple of the factor iff y times the
  // inverse, modulo 2^YEAR_BITS, does not exceed the largest year / factor.
  localparam logic [63:0] YEAR_MAX_W    = (64'd1 << YEAR_BITS) - 64'd1;
  localparam year_t       CENTURY_INV   = year_t'(odd_inverse(CenturyFactor));
  localparam year_t       CENTURY_LIMIT = year_t'(YEAR_MAX_W / CenturyFactor);

  // One date as carried through the pipeline.
  typedef struct packed {
    day_t   day;
    month_t month;
    year_t  year;
  } date_t;

  // One finished result.
  typedef struct packed {
    logic   valid_res;
    day_t   next_day;
    month_t next_month;
    year_t  next_year;
    day_t   prev_day;
    month_t prev_month;
    year_t  prev_year;
    order_t order;
  } result_t;

  // Length of a month; codes outside 1 to 12 have no days.
  function automatic day_t month_days(input month_t m, input logic leap);
    day_t len;
    unique case (m)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                       len = leap ? 5'd29 : 5'd28;
      default:                                    len = 5'd0;
    endcase
    return len;
  endfunction

endpackage

// File: hw/rtl/gdsc_calc.sv
// ----------------------------------------------------------------------------
// gdsc_calc
// Combinational date logic: validity, next day, previous day and ordering.
// ----------------------------------------------------------------------------
module gdsc_calc import gdsc_pkg::*; (
  input  date_t   date_i,
  input  date_t   other_i,
  output result_t result_o
);

  year_t  century_test;
  logic   div4;
  logic   div16;
  logic   div_century;
  logic   leap;
  day_t   dim;
  month_t pm_dec;
  logic   valid;

  // Leap year: multiple of 4 and not of 100, or multiple of 400.
  assign century_test = year_t'(date_i.year * CENTURY_INV);
  assign div4         = (date_i.year[1:0] == 2'b00);
  assign div16        = (date_i.year[3:0] == 4'b0000);
  assign div_century  = (century_test <= CENTURY_LIMIT);
  assign leap         = div4 && (!div_century || div16);

  assign dim    = month_days(date_i.month, leap);
  assign pm_dec = date_i.month - 4'd1;
  assign valid  = (date_i.month >= MONTH_JAN) && (date_i.month <= MONTH_DEC) &&
                  (date_i.day >= DAY_FIRST) && (date_i.day <= dim);

  // Following and preceding day, with month and year rollover.
  always_comb begin
    result_o            = '0;
    result_o.valid_res  = valid;
    if (valid) begin
      result_o.next_day   = date_i.day;
      result_o.next_month = date_i.month;
      result_o.next_year  = date_i.year;
      if (date_i.day < dim) begin
        result_o.next_day = date_i.day + 5'd1;
      end else begin
        result_o.next_day = DAY_FIRST;
        if (date_i.month < MONTH_DEC) begin
          result_o.next_month = date_i.month + 4'd1;
        end else begin
          result_o.next_month = MONTH_JAN;
          result_o.next_year  = date_i.year + year_t'(1);
        end
      end

      result_o.prev_day   = date_i.day;
      result_o.prev_month = date_i.month;
      result_o.prev_year  = date_i.year;
      priority if (date_i.day > DAY_FIRST) begin
        result_o.prev_day = date_i.day - 5'd1;
      end else if (date_i.month > MONTH_JAN) begin
        result_o.prev_month = pm_dec;
        result_o.prev_day   = month_days(pm_dec, leap);
      end else begin
        result_o.prev_year  = date_i.year - year_t'(1);
        result_o.prev_month = MONTH_DEC;
        result_o.prev_day   = DAY_LAST_DEC;
      end
    end

    // Ordering on the raw fields: year, then month, then day.
    priority if (date_i.year != other_i.year) begin
      result_o.order = (date_i.year < other_i.year) ? ORDER_EARLIER : ORDER_LATER;
    end else if (date_i.month != other_i.month) begin
      result_o.order = (date_i.month < other_i.month) ? ORDER_EARLIER : ORDER_LATER;
    end else if (date_i.day != other_i.day) begin
      result_o.order = (date_i.day < other_i.day) ? ORDER_EARLIER : ORDER_LATER;
    end else begin
      result_o.order = ORDER_EQUAL;
    end
  end

endmodule

// File: hw/rtl/gregorian_date_step_compare.sv
// An accepted item is registered in the input register and then in the result
// register, from which the receiver takes it.
// Throughput: one item per cycle while the output is not stalled; an item enters
// the input register and the date logic then feeds the result register.
// A stall holds a full result register, and the input register too when both are full.
// Reset clears the two valid flags; the payload registers are not reset.
// ----------------------------------------------------------------------------
// gregorian_date_step_compare
// Two-stage Gregorian date stepper: next day, previous day and ordering.
// ----------------------------------------------------------------------------
`include "gregorian_date_step_compare_assert.svh"

module gregorian_date_step_compare import gdsc_pkg::*; (
  input  logic   clk_i,
  input  logic   rst_ni,
  input  logic   valid_i,
  output logic   stall_o,
  input  day_t   day_i,
  input  month_t month_i,
  input  year_t  year_i,
  input  day_t   other_day_i,
  input  month_t other_month_i,
  input  year_t  other_year_i,
  output logic   valid_o,
  input  logic   stall_i,
  output logic   valid_res_o,
  output day_t   next_day_o,
  output month_t next_month_o,
  output year_t  next_year_o,
  output day_t   prev_day_o,
  output month_t prev_month_o,
  output year_t  prev_year_o,
  output order_t order_o
);

  logic    s1_valid_q;
  date_t   s1_date_q;
  date_t   s1_other_q;
  logic    out_valid_q;
  result_t out_q;
  result_t calc_res;
  logic    advance;
  logic    s1_load;

  // The result register moves whenever it is empty or being taken.
  assign advance = !(out_valid_q && stall_i);
  assign s1_load = !s1_valid_q || advance;
  assign stall_o = !s1_load;

  gdsc_calc u_calc (
    .date_i   (s1_date_q),
    .other_i  (s1_other_q),
    .result_o (calc_res)
  );

  // Valid flags of both stages.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (s1_load) begin
        s1_valid_q <= valid_i;
      end
      if (advance) begin
        out_valid_q <= s1_valid_q;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (s1_load && valid_i) begin
      s1_date_q  <= '{day: day_i, month: month_i, year: year_i};
      s1_other_q <= '{day: other_day_i, month: other_month_i, year: other_year_i};
    end
    if (advance && s1_valid_q) begin
      out_q <= calc_res;
    end
  end

  assign valid_o      = out_valid_q;
  assign valid_res_o  = out_q.valid_res;
  assign next_day_o   = out_q.next_day;
  assign next_month_o = out_q.next_month;
  assign next_year_o  = out_q.next_year;
  assign prev_day_o   = out_q.prev_day;
  assign prev_month_o = out_q.prev_month;
  assign prev_year_o  = out_q.prev_year;
  assign order_o      = out_q.order;

  // A filled input stage reaches the output when the pipeline moves.
  `GDSC_ASSERT_NEXT(a_stage_moves, advance && s1_valid_q, valid_o, "input stage item was lost")

  // A valid date steps to real months on both sides.
  `GDSC_ASSERT_SAME(a_month_range, valid_o && valid_res_o,
    next_month_o >= MONTH_JAN && next_month_o <= MONTH_DEC &&
    prev_month_o >= MONTH_JAN && prev_month_o <= MONTH_DEC, "stepped month out of range")

  // An invalid date carries zero neighbors.
  `GDSC_ASSERT_SAME(a_invalid_zero, valid_o && !valid_res_o,
    next_day_o == '0 && next_month_o == '0 && next_year_o == '0 &&
    prev_day_o == '0 && prev_month_o == '0 && prev_year_o == '0, "invalid date not zeroed")

  // Away from a year boundary both neighbors share the year.
  `GDSC_ASSERT_SAME(a_same_year, valid_o && valid_res_o && next_month_o != MONTH_JAN &&
    prev_month_o != MONTH_DEC, next_year_o == prev_year_o, "year changed mid-year")

  // The stall is raised only while both stages are full.
  `GDSC_ASSERT_SAME(a_stall_full, stall_o, s1_valid_q && out_valid_q, "stall with room left")

endmodule

// File: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Testbench for gregorian_date_step_compare
// Sends dates through the valid/stall input channel and checks each result
// against a predictor of the next day, the previous day and the ordering.
// Directed tests cover month and year rollover, the year wrap, the leap-year
// rules, invalid dates and every ordering outcome. A random test then sends
// mostly well-formed dates with random bursts on the sender and stalls on the
// receiver. A long receiver hold-off makes the block fill up and stall.
// ----------------------------------------------------------------------------
module tb import gdsc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomItems  = 2000;
  localparam int unsigned RandomPhases = 8;
  localparam int unsigned HoldCycles   = 80;
  localparam int unsigned DrainLimit   = 20000;
  localparam int unsigned TailCycles   = 4;
  localparam int unsigned ReportLimit  = 10;

  typedef enum int {STALL_NONE, STALL_RANDOM, STALL_PATTERN} stall_mode_e;

  // Days of each month code in a common year; codes outside 1 to 12 have none.
  localparam day_t MonthLen [16] = '{
    5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
    5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31, 5'd0, 5'd0, 5'd0
  };

  logic   clk_i = 1'b0;
  logic   rst_ni = 1'b0;
  logic   valid_i = 1'b0;
  logic   stall_o;
  day_t   day_i = '0;
  month_t month_i = '0;
  year_t  year_i = '0;
  day_t   other_day_i = '0;
  month_t other_month_i = '0;
  year_t  other_year_i = '0;
  logic   valid_o;
  logic   stall_i = 1'b0;
  logic   valid_res_o;
  day_t   next_day_o;
  month_t next_month_o;
  year_t  next_year_o;
  day_t   prev_day_o;
  month_t prev_month_o;
  year_t  prev_year_o;
  order_t order_o;

  result_t     pending_results[$];
  int unsigned fail_count = 0;
  bit          sender_gaps = 1'b0;
  int unsigned burst_left = 0;
  stall_mode_e stall_mode = STALL_NONE;
  logic [15:0] stall_pattern = 16'h0;
  int unsigned pattern_idx = 0;
  logic        hold_active = 1'b0;

  gregorian_date_step_compare DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .valid_i      (valid_i),
    .stall_o      (stall_o),
    .day_i        (day_i),
    .month_i      (month_i),
    .year_i       (year_i),
    .other_day_i  (other_day_i),
    .other_month_i(other_month_i),
    .other_year_i (other_year_i),
    .valid_o      (valid_o),
    .stall_i      (stall_i),
    .valid_res_o  (valid_res_o),
    .next_day_o   (next_day_o),
    .next_month_o (next_month_o),
    .next_year_o  (next_year_o),
    .prev_day_o   (prev_day_o),
    .prev_month_o (prev_month_o),
    .prev_year_o  (prev_year_o),
    .order_o      (order_o)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Gregorian rule: every fourth year, except centuries not divisible by 400.
  function automatic bit is_leap_year(year_t y);
    int unsigned v;
    v = 32'(y);
    return ((v % 4) == 0 && (v % 100) != 0) || (v % 400) == 0;
  endfunction

  function automatic day_t month_length(month_t m, year_t y);
    if (m == MONTH_FEB && is_leap_year(y)) begin
      return 5'd29;
    end
    return MonthLen[m];
  endfunction

  // Expected result of one date item.
  function automatic result_t predict_date_step(day_t d, month_t m, year_t y,
                                                day_t od, month_t om, year_t oy);
    result_t r;
    day_t    dim;
    r = '0;
    dim = month_length(m, y);
    r.valid_res = (m >= MONTH_JAN && m <= MONTH_DEC && d >= DAY_FIRST && d <= dim);
    if (r.valid_res) begin
      // Following day, rolling into the next month or year.
      r.next_year = y;
      if (d < dim) begin
        r.next_day = d + 1'b1;
        r.next_month = m;
      end else if (m < MONTH_DEC) begin
        r.next_day = DAY_FIRST;
        r.next_month = m + 1'b1;
      end else begin
        r.next_day = DAY_FIRST;
        r.next_month = MONTH_JAN;
        r.next_year = y + 1'b1;
      end
      // Preceding day, falling back into the previous month or year.
      r.prev_year = y;
      if (d > DAY_FIRST) begin
        r.prev_day = d - 1'b1;
        r.prev_month = m;
      end else if (m > MONTH_JAN) begin
        r.prev_month = m - 1'b1;
        r.prev_day = month_length(m - 1'b1, y);
      end else begin
        r.prev_day = DAY_LAST_DEC;
        r.prev_month = MONTH_DEC;
        r.prev_year = y - 1'b1;
      end
    end
    // Ordering works on the raw fields, valid or not.
    if (y != oy) begin
      r.order = (y < oy) ? ORDER_EARLIER : ORDER_LATER;
    end else if (m != om) begin
      r.order = (m < om) ? ORDER_EARLIER : ORDER_LATER;
    end else if (d != od) begin
      r.order = (d < od) ? ORDER_EARLIER : ORDER_LATER;
    end else begin
      r.order = ORDER_EQUAL;
    end
    return r;
  endfunction

  function automatic string fmt_result(result_t r);
    return $sformatf("valid=%0d next=%0d/%0d/%0d prev=%0d/%0d/%0d order=%0d",
                     r.valid_res, r.next_day, r.next_month, r.next_year,
                     r.prev_day, r.prev_month, r.prev_year, r.order);
  endfunction

  task automatic report_failure(string msg);
    fail_count++;
    if (fail_count <= ReportLimit) begin
      $display("[%0t] ERROR: %s", $realtime, msg);
    end
  endtask

  // Sends one date item and records its expected result once accepted.
  task automatic send_date(day_t d, month_t m, year_t y,
                           day_t od, month_t om, year_t oy);
    result_t exp_res;
    int unsigned gap;
    exp_res = predict_date_step(d, m, y, od, om, oy);
    if (sender_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 6);
      valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
      burst_left = $urandom_range(1, 16);
    end
    if (burst_left > 0) burst_left--;
    valid_i       <= 1'b1;
    day_i         <= d;
    month_i       <= m;
    year_i        <= y;
    other_day_i   <= od;
    other_month_i <= om;
    other_year_i  <= oy;
    do @(posedge clk_i); while (stall_o);
    pending_results.push_back(exp_res);
  endtask

  // Drops valid and waits for every outstanding result.
  task automatic wait_results_drained();
    int unsigned waited;
    waited = 0;
    valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_results.size() != 0 && waited < DrainLimit) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_results.size() != 0) begin
      report_failure($sformatf("timeout with %0d results outstanding",
                               pending_results.size()));
    end
  endtask

  // Receiver stall pattern, overridden by the long hold-off.
  always @(posedge clk_i) begin
    case (stall_mode)
      STALL_RANDOM: begin
        stall_i <= hold_active | ($urandom_range(0, 99) < 40);
      end
      STALL_PATTERN: begin
        stall_i <= hold_active | stall_pattern[pattern_idx % 16];
        pattern_idx++;
      end
      default: begin
        stall_i <= hold_active;
      end
    endcase
  end

  // Compare each accepted result with the oldest expectation.
  always @(posedge clk_i) begin
    result_t exp_res;
    result_t got;
    string   bad;
    if (rst_ni && valid_o && !stall_i) begin
      got = '{valid_res_o, next_day_o, next_month_o, next_year_o,
              prev_day_o, prev_month_o, prev_year_o, order_o};
      if (pending_results.size() == 0) begin
        report_failure({"unexpected result: ", fmt_result(got)});
      end else begin
        exp_res = pending_results.pop_front();
        bad = "";
        if (got.valid_res !== exp_res.valid_res) bad = {bad, " valid_res"};
        if (got.next_day !== exp_res.next_day) bad = {bad, " next_day"};
        if (got.next_month !== exp_res.next_month) bad = {bad, " next_month"};
        if (got.next_year !== exp_res.next_year) bad = {bad, " next_year"};
        if (got.prev_day !== exp_res.prev_day) bad = {bad, " prev_day"};
        if (got.prev_month !== exp_res.prev_month) bad = {bad, " prev_month"};
        if (got.prev_year !== exp_res.prev_year) bad = {bad, " prev_year"};
        if (got.order !== exp_res.order) bad = {bad, " order"};
        if (bad != "") begin
          report_failure($sformatf("mismatch in%s: expected %s, got %s", bad,
                                   fmt_result(exp_res), fmt_result(got)));
        end
      end
    end
  end

  // Day and month rollover in both directions.
  task automatic test_month_rollover();
    send_date(5'd30, 4'd4, 16'd2021, 5'd30, 4'd4, 16'd2021);
    send_date(5'd1, 4'd5, 16'd2021, 5'd1, 4'd5, 16'd2021);
    send_date(5'd31, 4'd1, 16'd2022, 5'd1, 4'd2, 16'd2022);
    send_date(5'd15, 4'd7, 16'd1999, 5'd16, 4'd7, 16'd1999);
    send_date(5'd1, 4'd1, 16'd2024, 5'd31, 4'd12, 16'd2023);
    send_date(5'd31, 4'd12, 16'd2023, 5'd1, 4'd1, 16'd2024);
  endtask

  // The year after the largest year is zero and the year before zero is the largest.
  task automatic test_year_wrap();
    send_date(5'd31, 4'd12, 16'hFFFF, 5'd0, 4'd0, 16'h0000);
    send_date(5'd1, 4'd1, 16'h0000, 5'd31, 4'd15, 16'hFFFF);
  endtask

  // Common years, leap years, century years and years divisible by 400.
  task automatic test_leap_rules();
    send_date(5'd28, 4'd2, 16'd2023, 5'd28, 4'd2, 16'd2023);
    send_date(5'd29, 4'd2, 16'd2024, 5'd1, 4'd3, 16'd2024);
    send_date(5'd29, 4'd2, 16'd1900, 5'd29, 4'd2, 16'd1900);
    send_date(5'd29, 4'd2, 16'd2000, 5'd28, 4'd2, 16'd2000);
    send_date(5'd1, 4'd3, 16'd2024, 5'd1, 4'd3, 16'd2025);
    send_date(5'd1, 4'd3, 16'd1900, 5'd1, 4'd3, 16'd1800);
    send_date(5'd1, 4'd3, 16'd0, 5'd1, 4'd3, 16'd0);
  endtask

  // Months out of range, day zero, days past the month end, all-ones fields.
  task automatic test_invalid_dates();
    send_date(5'd10, 4'd0, 16'd2020, 5'd10, 4'd0, 16'd2020);
    send_date(5'd10, 4'd13, 16'd2020, 5'd10, 4'd12, 16'd2020);
    send_date(5'd31, 4'd15, 16'hFFFF, 5'd31, 4'd15, 16'hFFFF);
    send_date(5'd0, 4'd6, 16'd1234, 5'd1, 4'd6, 16'd1234);
    send_date(5'd31, 4'd4, 16'd2021, 5'd30, 4'd4, 16'd2021);
  endtask

  // Ordering decided by year, by month and by day.
  task automatic test_ordering();
    send_date(5'd5, 4'd3, 16'd100, 5'd5, 4'd3, 16'd101);
    send_date(5'd5, 4'd3, 16'd100, 5'd4, 4'd3, 16'd100);
    send_date(5'd5, 4'd11, 16'd100, 5'd20, 4'd2, 16'd100);
  endtask

  // Mostly well-formed dates near the interesting boundaries, some noise.
  task automatic test_random_dates();
    day_t        d;
    day_t        od;
    month_t      m;
    month_t      om;
    year_t       y;
    year_t       oy;
    day_t        dim;
    int unsigned per_phase;
    per_phase = RandomItems / RandomPhases;
    for (int unsigned phase = 0; phase < RandomPhases; phase++) begin
      sender_gaps = (phase != 0) && ($urandom_range(0, 3) != 0);
      stall_mode = stall_mode_e'(phase % 3);
      // Keep at least one open slot so the receiver never stalls for good.
      stall_pattern = 16'($urandom) & ~16'h0001;
      for (int unsigned n = 0; n < per_phase; n++) begin
        if ($urandom_range(0, 99) < 15) begin
          // Noise: any value of every field.
          d = 5'($urandom); m = 4'($urandom); y = 16'($urandom);
          od = 5'($urandom); om = 4'($urandom); oy = 16'($urandom);
        end else begin
          case ($urandom_range(0, 5))
            0:       y = 16'($urandom_range(0, 163) * 400);
            1:       y = 16'($urandom_range(0, 655) * 100);
            2:       y = 16'($urandom_range(0, 16383) * 4);
            3:       y = $urandom_range(0, 1) ? 16'($urandom_range(0, 2))
                                              : 16'hFFFF - 16'($urandom_range(0, 2));
            default: y = 16'($urandom);
          endcase
          m = 4'($urandom_range(1, 12));
          if ($urandom_range(0, 3) == 0) m = $urandom_range(0, 1) ? MONTH_JAN : MONTH_DEC;
          dim = month_length(m, y);
          case ($urandom_range(0, 9))
            0, 1, 2: d = dim;
            3, 4:    d = DAY_FIRST;
            5:       d = dim + 1'b1;
            default: d = 5'($urandom_range(1, dim));
          endcase
          // Second date: often equal or close so that every ordering level decides.
          case ($urandom_range(0, 4))
            0:       begin od = d; om = m; oy = y; end
            1:       begin od = 5'($urandom); om = m; oy = y; end
            2:       begin od = 5'($urandom); om = 4'($urandom); oy = y; end
            3:       begin od = d; om = m; oy = y + 16'($urandom_range(0, 2)) - 1'b1; end
            default: begin od = 5'($urandom); om = 4'($urandom); oy = 16'($urandom); end
          endcase
        end
        send_date(d, m, y, od, om, oy);
      end
      wait_results_drained();
    end
  endtask

  // The receiver holds off for a long stretch while items keep coming.
  task automatic test_backpressure();
    sender_gaps = 1'b0;
    stall_mode = STALL_NONE;
    fork
      begin
        hold_active <= 1'b1;
        repeat (HoldCycles) @(posedge clk_i);
        hold_active <= 1'b0;
      end
    join_none
    for (int unsigned n = 0; n < 30; n++) begin
      send_date(5'($urandom_range(1, 28)), 4'($urandom_range(1, 12)), 16'($urandom),
                5'($urandom), 4'($urandom), 16'($urandom));
    end
    wait_results_drained();
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    stall_mode = STALL_RANDOM;
    sender_gaps = 1'b1;
    test_month_rollover();
    test_year_wrap();
    test_leap_rules();
    test_invalid_dates();
    test_ordering();
    wait_results_drained();

    test_backpressure();
    test_random_dates();
    test_backpressure();

    // Let any stray result show up before the verdict.
    stall_mode = STALL_NONE;
    repeat (TailCycles) @(posedge clk_i);
    if (fail_count == 0 && pending_results.size() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

  // Run limit, far beyond the slowest correct run.
  initial begin
    #5ms;
    $display("Test completed with failures");
    $finish;
  end

endmodule
